/* sv/cbm_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cbm_pkg: shared definitions for the cartridge bank mapper
// Mapper kinds, result target codes, register indexes and field widths.
// ----------------------------------------------------------------------------
package cbm_pkg;

  localparam int MAX_ROM_BANKS_DEF = 128;

  localparam int ADDR_W   = 16;
  localparam int DATA_W   = 8;
  localparam int MAPPED_W = 21;
  localparam int TGT_W    = 3;
  localparam int CFG_IDX_W = 1;

  typedef enum logic [1:0] {
    KIND_NONE = 2'd0,
    KIND_MBC1 = 2'd1,
    KIND_MBC2 = 2'd2,
    KIND_MBC3 = 2'd3
  } kind_t;

  typedef enum logic [TGT_W-1:0] {
    TGT_REG     = 3'd0,
    TGT_ROM     = 3'd1,
    TGT_RAM     = 3'd2,
    TGT_REFUSED = 3'd3,
    TGT_PASS    = 3'd4,
    TGT_IGNORED = 3'd5
  } target_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MAPPER_KIND    = 1'b0,
    CFG_ROM_BANK_COUNT = 1'b1
  } cfg_index_t;

  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_READ  = 1'b1;

  localparam logic [DATA_W-1:0] MBC1_BANK_MASK = 8'h1F;
  localparam logic [DATA_W-1:0] MBC2_BANK_MASK = 8'h0F;
  localparam logic [DATA_W-1:0] MBC3_BANK_MASK = 8'h7F;
  localparam logic [3:0]        RAM_ENABLE_KEY = 4'hA;

endpackage
`default_nettype wire

/* sv/cbm_if.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cbm_if: handshake channels of the cartridge bank mapper
// Bus access words in, translated words out, and the register write channel.
// ----------------------------------------------------------------------------
interface cbm_in_if;
  logic                        valid;
  logic                        ready;
  logic                        opcode;
  logic [cbm_pkg::ADDR_W-1:0]  address;
  logic [cbm_pkg::DATA_W-1:0]  write_data;

  modport source (output valid, output opcode, output address, output write_data,
                  input ready);
  modport sink   (input valid, input opcode, input address, input write_data,
                  output ready);
endinterface

interface cbm_out_if;
  logic                          valid;
  logic                          ready;
  logic [cbm_pkg::TGT_W-1:0]     target;
  logic [cbm_pkg::MAPPED_W-1:0]  mapped_address;

  modport source (output valid, output target, output mapped_address, input ready);
  modport sink   (input valid, input target, input mapped_address, output ready);
endinterface

interface cbm_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [cbm_pkg::CFG_IDX_W-1:0]  index;
  logic [cbm_pkg::DATA_W-1:0]     data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

/* sv/cartridge_bank_mapper.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cartridge_bank_mapper: cartridge bank controller for none, MBC1, MBC2, MBC3
// Programs the bank registers from bus writes and translates ROM and
// cartridge RAM accesses to physical addresses.
// ----------------------------------------------------------------------------
// Each bus access word is taken into an input register, translated there by
// a single pass of logic against the current bank registers, and placed in
// the result register; the bank registers update as the word leaves the input
// register, so a bank write governs the very next access. The block takes one
// word per clock while the result side does not stall, and returns one word
// per access. Register writes on the cfg channel are always accepted and are
// meant for idle periods only.
module cartridge_bank_mapper #(
  parameter int MAX_ROM_BANKS = cbm_pkg::MAX_ROM_BANKS_DEF
) (
  input  wire         clk,
  input  wire         rst_n,
  cbm_in_if.sink      in_ch,
  cbm_out_if.source   out_ch,
  cbm_cfg_if.sink     cfg_ch
);

  localparam logic [cbm_pkg::DATA_W-1:0] MAX_MASK = cbm_pkg::DATA_W'(MAX_ROM_BANKS - 1);

  // configuration
  cbm_pkg::kind_t               kind_r;
  logic [cbm_pkg::DATA_W-1:0]   count_r;

  // bank state
  logic [6:0] rom_sel_r, rom_sel_nxt;
  logic [1:0] ram_sel_r, ram_sel_nxt;
  logic       mode_r, mode_nxt;
  logic       locked_r, locked_nxt;

  // input register
  logic                         s_valid_r;
  logic                         s_opcode_r;
  logic [cbm_pkg::ADDR_W-1:0]   s_addr_r;
  logic [cbm_pkg::DATA_W-1:0]   s_data_r;

  // result register
  logic                           o_valid_r;
  cbm_pkg::target_t               o_tgt_r, tgt_nxt;
  logic [cbm_pkg::MAPPED_W-1:0]   o_mapped_r, mapped_nxt;

  logic out_free, advance, in_take;

  assign out_free = !o_valid_r || out_ch.ready;
  assign advance  = s_valid_r && out_free;
  assign in_ch.ready = !s_valid_r || out_free;
  assign in_take  = in_ch.valid && in_ch.ready;
  assign cfg_ch.ready = 1'b1;

  assign out_ch.valid          = o_valid_r;
  assign out_ch.target         = o_tgt_r;
  assign out_ch.mapped_address = o_mapped_r;

  // translation
  logic       is_write;
  logic [1:0] region;
  logic [6:0] eff_bank, bank;
  logic [cbm_pkg::DATA_W-1:0] count_mask;
  logic [cbm_pkg::DATA_W-1:0] v1, v2, v3;

  always_comb begin
    is_write   = (s_opcode_r == cbm_pkg::OP_WRITE);
    region     = s_addr_r[14:13];
    count_mask = (count_r - 8'd1) & MAX_MASK;
    v1         = s_data_r & cbm_pkg::MBC1_BANK_MASK;
    v2         = s_data_r & cbm_pkg::MBC2_BANK_MASK;
    v3         = s_data_r & cbm_pkg::MBC3_BANK_MASK;
    if (kind_r == cbm_pkg::KIND_MBC1) begin
      eff_bank = {(mode_r ? 2'b00 : ram_sel_r), rom_sel_r[4:0]};
    end else begin
      eff_bank = (rom_sel_r == 7'd0) ? 7'd1 : rom_sel_r;
    end
    bank = eff_bank & count_mask[6:0];

    rom_sel_nxt = rom_sel_r;
    ram_sel_nxt = ram_sel_r;
    mode_nxt    = mode_r;
    locked_nxt  = locked_r;
    tgt_nxt     = cbm_pkg::TGT_PASS;
    mapped_nxt  = {5'd0, s_addr_r};

    if (!s_addr_r[15]) begin
      if (is_write) begin
        mapped_nxt = '0;
        tgt_nxt    = cbm_pkg::TGT_REG;
        if (kind_r == cbm_pkg::KIND_NONE) begin
          tgt_nxt = cbm_pkg::TGT_IGNORED;
        end else begin
          case (region)
            2'd0: begin
              if (kind_r == cbm_pkg::KIND_MBC2 && s_addr_r[8]) begin
                tgt_nxt = cbm_pkg::TGT_IGNORED;
              end else begin
                locked_nxt = (s_data_r[3:0] != cbm_pkg::RAM_ENABLE_KEY);
              end
            end
            2'd1: begin
              if (kind_r == cbm_pkg::KIND_MBC1) begin
                rom_sel_nxt = (v1 == 8'd0) ? 7'd1 : v1[6:0];
              end else if (kind_r == cbm_pkg::KIND_MBC2) begin
                if (!s_addr_r[8]) begin
                  tgt_nxt = cbm_pkg::TGT_IGNORED;
                end else begin
                  rom_sel_nxt = (v2 == 8'd0) ? 7'd1 : v2[6:0];
                end
              end else begin
                rom_sel_nxt = v3[6:0];
              end
            end
            2'd2: begin
              if (kind_r == cbm_pkg::KIND_MBC3 && s_data_r[7:2] != 6'd0) begin
                tgt_nxt = cbm_pkg::TGT_IGNORED;
              end else begin
                ram_sel_nxt = s_data_r[1:0];
              end
            end
            default: begin
              if (kind_r == cbm_pkg::KIND_MBC3) begin
                tgt_nxt = cbm_pkg::TGT_IGNORED;
              end else begin
                mode_nxt = s_data_r[0];
              end
            end
          endcase
        end
      end else begin
        tgt_nxt = cbm_pkg::TGT_ROM;
        if (!s_addr_r[14] || kind_r == cbm_pkg::KIND_NONE) begin
          mapped_nxt = {5'd0, s_addr_r};
        end else begin
          mapped_nxt = {bank, s_addr_r[13:0]};
        end
      end
    end else if (s_addr_r[15:13] == 3'b101 && kind_r != cbm_pkg::KIND_NONE) begin
      if (is_write && locked_r) begin
        tgt_nxt    = cbm_pkg::TGT_REFUSED;
        mapped_nxt = '0;
      end else begin
        tgt_nxt = cbm_pkg::TGT_RAM;
        if (kind_r == cbm_pkg::KIND_MBC3 || mode_r) begin
          mapped_nxt = {6'd0, ram_sel_r, s_addr_r[12:0]};
        end else begin
          mapped_nxt = {8'd0, s_addr_r[12:0]};
        end
      end
    end
  end

  // control and bank state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kind_r    <= cbm_pkg::KIND_NONE;
      count_r   <= 8'd2;
      rom_sel_r <= 7'd1;
      ram_sel_r <= 2'd0;
      mode_r    <= 1'b0;
      locked_r  <= 1'b1;
      s_valid_r <= 1'b0;
      o_valid_r <= 1'b0;
    end else begin
      if (cfg_ch.valid) begin
        unique case (cbm_pkg::cfg_index_t'(cfg_ch.index))
          cbm_pkg::CFG_MAPPER_KIND:    kind_r  <= cbm_pkg::kind_t'(cfg_ch.data[1:0]);
          cbm_pkg::CFG_ROM_BANK_COUNT: count_r <= cfg_ch.data;
          default: ;
        endcase
      end
      if (advance) begin
        rom_sel_r <= rom_sel_nxt;
        ram_sel_r <= ram_sel_nxt;
        mode_r    <= mode_nxt;
        locked_r  <= locked_nxt;
      end
      if (in_ch.ready) begin
        s_valid_r <= in_ch.valid;
      end
      if (out_free) begin
        o_valid_r <= s_valid_r;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_take) begin
      s_opcode_r <= in_ch.opcode;
      s_addr_r   <= in_ch.address;
      s_data_r   <= in_ch.write_data;
    end
    if (advance) begin
      o_tgt_r    <= tgt_nxt;
      o_mapped_r <= mapped_nxt;
    end
  end

`ifndef SYNTHESIS
  a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ch.ready |-> (s_valid_r && o_valid_r && !out_ch.ready))
    else $error("input stalled while a stage is free");

  a_no_addr_on_dead_word: assert property (@(posedge clk) disable iff (!rst_n)
    (o_valid_r && (o_tgt_r == cbm_pkg::TGT_REG || o_tgt_r == cbm_pkg::TGT_REFUSED ||
                   o_tgt_r == cbm_pkg::TGT_IGNORED)) |-> (o_mapped_r == '0))
    else $error("address on a word that carries none");

  a_ram_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (o_valid_r && o_tgt_r == cbm_pkg::TGT_RAM) |-> (o_mapped_r[20:15] == 6'd0))
    else $error("cartridge ram address out of range");

  a_lock_moves_on_advance: assert property (@(posedge clk) disable iff (!rst_n)
    ($past(rst_n) && !$stable(locked_r)) |-> $past(advance))
    else $error("ram lock changed without a word");
`endif

endmodule
`default_nettype wire
